// File: hdl/efb_pkg.sv
// Shared types and constants of the escaped frame builder.
`default_nettype none
package efb_pkg;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw    = $clog2(QDepth);

	localparam logic [7:0] RESERVED_A  = 8'h02;
	localparam logic [7:0] RESERVED_B  = 8'h03;
	localparam logic [7:0] START_RESET = 8'h02;
	localparam logic [7:0] STOP_RESET  = 8'h03;
	localparam logic [7:0] ESC_RESET   = 8'h10;
	localparam logic [7:0] LEN_EXTRA   = 8'd3;

	typedef enum logic [1:0] {
		CFG_START  = 2'd0,
		CFG_STOP   = 2'd1,
		CFG_ESCAPE = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		KIND_BEGIN   = 1'b0,
		KIND_PAYLOAD = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_START = 3'd0,
		ST_ALO   = 3'd1,
		ST_AHI   = 3'd2,
		ST_LEN   = 3'd3,
		ST_OP    = 3'd4,
		ST_DATA  = 3'd5,
		ST_SUM   = 3'd6,
		ST_STOP  = 3'd7
	} step_t;

	typedef struct packed {
		logic [7:0] start_code;
		logic [7:0] stop_code;
		logic [7:0] escape_code;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] addr;
		logic [7:0]  opcode;
		logic [7:0]  len;
		logic [7:0]  data;
		logic        close;
		logic [7:0]  sum;
	} token_t;

endpackage
`default_nettype wire

// File: hdl/efb_front.sv
// Front end: accepts items, tracks the open frame and builds tokens.
`default_nettype none
module efb_front
	import efb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,
	input  wire logic        s_axis_tuser,
	input  wire logic        q_full,
	output logic             q_push,
	output token_t           q_data
);

	logic       in_frame_q;
	logic [7:0] left_q;
	logic [7:0] sum_q;

	logic        accept;
	logic [15:0] addr;
	logic [7:0]  opcode;
	logic [7:0]  count;
	logic [7:0]  pbyte;
	logic [7:0]  len;
	logic [7:0]  hdr_sum;
	logic [7:0]  pay_sum;
	logic        is_begin;

	assign addr     = s_axis_tdata[15:0];
	assign opcode   = s_axis_tdata[23:16];
	assign count    = s_axis_tdata[31:24];
	assign pbyte    = s_axis_tdata[39:32];
	assign is_begin = (kind_t'(s_axis_tuser) == KIND_BEGIN);
	assign len      = count + LEN_EXTRA;
	assign hdr_sum  = addr[7:0] + addr[15:8] + len + opcode;
	assign pay_sum  = sum_q + pbyte;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign q_push        = accept && (is_begin || in_frame_q);

	always_comb begin
		q_data.kind   = kind_t'(s_axis_tuser);
		q_data.addr   = addr;
		q_data.opcode = opcode;
		q_data.len    = len;
		q_data.data   = pbyte;
		if (is_begin) begin
			q_data.close = (count == 8'd0);
			q_data.sum   = hdr_sum;
		end else begin
			q_data.close = (left_q == 8'd1);
			q_data.sum   = pay_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			left_q     <= 8'd0;
			sum_q      <= 8'd0;
		end else if (accept) begin
			if (is_begin) begin
				in_frame_q <= (count != 8'd0);
				left_q     <= count;
				sum_q      <= hdr_sum;
			end else if (in_frame_q) begin
				left_q <= left_q - 8'd1;
				if (left_q == 8'd1) begin
					in_frame_q <= 1'b0;
					sum_q      <= 8'd0;
				end else begin
					sum_q <= pay_sum;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/efb_fifo.sv
// Short token queue between front and back.
`default_nettype none
module efb_fifo
	import efb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  token_t    push_data,
	output logic      full,
	input  wire logic pop,
	output token_t    pop_data,
	output logic      not_empty
);

	token_t            mem_q [QDepth];
	logic [QAw-1:0]    wr_q;
	logic [QAw-1:0]    rd_q;
	logic [QAw:0]      cnt_q;

	assign full      = (cnt_q == (QAw+1)'(QDepth));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAw'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAw'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QAw+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QAw+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/efb_back.sv
// Back end: walks each token byte by byte, inserts escapes, drives the output register.
`default_nettype none
module efb_back
	import efb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  cfg_t            cfg,
	input  wire logic       q_not_empty,
	input  token_t          q_data,
	output logic            q_pop,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,
	output logic            m_axis_tuser,
	output logic            m_axis_tlast
);

	token_t     cur_q;
	logic       busy_q;
	step_t      step_q;
	logic       esc_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_end_q;
	logic       out_last_q;

	step_t      step_d;
	logic       esc_d;
	logic       emit;
	logic       fin;
	logic       send_esc;
	logic       raw;
	logic [7:0] cur_byte;
	logic [7:0] emit_byte;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_end_q;
	assign m_axis_tlast  = out_last_q;

	assign emit  = busy_q && (!out_valid_q || m_axis_tready);
	assign q_pop = q_not_empty && (!busy_q || (emit && fin));

	always_comb begin
		case (step_q)
			ST_START: cur_byte = cfg.start_code;
			ST_ALO:   cur_byte = cur_q.addr[7:0];
			ST_AHI:   cur_byte = cur_q.addr[15:8];
			ST_LEN:   cur_byte = cur_q.len;
			ST_OP:    cur_byte = cur_q.opcode;
			ST_DATA:  cur_byte = cur_q.data;
			ST_SUM:   cur_byte = cur_q.sum;
			ST_STOP:  cur_byte = cfg.stop_code;
			default:  cur_byte = cur_q.data;
		endcase
		raw       = (step_q == ST_START) || (step_q == ST_STOP);
		send_esc  = !raw && !esc_q && ((cur_byte == cfg.escape_code) ||
			(cur_byte == RESERVED_A) || (cur_byte == RESERVED_B));
		emit_byte = send_esc ? cfg.escape_code : cur_byte;
		step_d    = step_q;
		esc_d     = esc_q;
		fin       = 1'b0;
		if (send_esc) begin
			esc_d = 1'b1;
		end else begin
			esc_d = 1'b0;
			case (step_q)
				ST_START: step_d = ST_ALO;
				ST_ALO:   step_d = ST_AHI;
				ST_AHI:   step_d = ST_LEN;
				ST_LEN:   step_d = ST_OP;
				ST_OP: begin
					step_d = ST_SUM;
					fin    = !cur_q.close;
				end
				ST_DATA: begin
					step_d = ST_SUM;
					fin    = !cur_q.close;
				end
				ST_SUM:   step_d = ST_STOP;
				ST_STOP:  fin = 1'b1;
				default:  fin = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (emit) begin
			out_byte_q <= emit_byte;
			out_end_q  <= !send_esc && (step_q == ST_STOP);
			out_last_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= ST_START;
			esc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				esc_q  <= 1'b0;
				step_q <= (q_data.kind == KIND_BEGIN) ? ST_START : ST_DATA;
			end else if (emit) begin
				busy_q <= !fin;
				esc_q  <= esc_d;
				step_q <= step_d;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/escaped_frame_builder.sv
// Top level of the escaped frame builder.
//
// Input words arrive on s_axis: tuser selects a begin word (0) carrying address,
// opcode and payload count, or a payload word (1) carrying one data byte.
// Payload words outside an open frame are taken and dropped.
// Output words leave on m_axis one byte at a time: tuser marks the stop code,
// tlast marks the last byte produced by one input word.
// The cfg channel writes start, stop and escape codes; it is always ready.
// Write it only while the block is idle.
// The front tracks frame state and checksum and pushes one token per kept word
// into a four-entry queue; the back walks the token and emits one byte a cycle
// while the receiver accepts. A payload word produces 1 to 5 bytes, a begin
// word 5 to 12, all through the back's single byte lane.
// A first byte passes the queue, the token register and the output register.
// Reset empties the queue and output register and restores the default codes.
// When the receiver stalls, the output word holds, the queue fills, and
// s_axis_tready falls once four tokens wait.
`default_nettype none
module escaped_frame_builder
	import efb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // frame_address, opcode, payload_count, payload_byte
	input  wire logic        s_axis_tuser,  // command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // out_byte
	output logic             m_axis_tuser,  // frame_end
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	cfg_t   cfg_q;
	token_t push_data;
	token_t pop_data;
	logic   push;
	logic   pop;
	logic   full;
	logic   not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code  <= START_RESET;
			cfg_q.stop_code   <= STOP_RESET;
			cfg_q.escape_code <= ESC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_START:  cfg_q.start_code  <= cfg_data;
				CFG_STOP:   cfg_q.stop_code   <= cfg_data;
				CFG_ESCAPE: cfg_q.escape_code <= cfg_data;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	efb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (full),
		.q_push        (push),
		.q_data        (push_data)
	);

	efb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	efb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_not_empty   (not_empty),
		.q_data        (pop_data),
		.q_pop         (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

// File: hdl/efb_checker.sv
// Port-level checks of the escaped frame builder and their binding.
`default_nettype none
module efb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tuser,
	input wire logic       m_axis_tlast
);

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("stop code not marked as last byte of its word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("stalled output word changed");

	a_reset_idle: assert property (@(posedge clk)
		$past(!arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");

endmodule

bind escaped_frame_builder efb_checker u_efb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: tb/tb_escaped_frame_builder.sv
// Self-checking testbench for the escaped frame builder: directed table and random frames.
`default_nettype none
module tb_escaped_frame_builder;
	timeunit 1ns;
	timeprecision 1ps;

	import efb_pkg::*;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned SETTLE      = 12;
	localparam int unsigned IDLE_PCT    = 26;

	typedef struct packed {
		logic [7:0] data;
		logic       is_stop;
		logic       is_last;
	} wire_byte_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] addr;
		logic [7:0]  op;
		logic [7:0]  cnt;
		logic [7:0]  dat;
		logic        typed;
		logic [3:0]  n;
		logic [95:0] bytes;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [39:0] s_tdata = '0;
	kind_t       s_tuser = KIND_BEGIN;
	logic        m_tready = 1'b0;
	logic        cfg_valid = 1'b0;
	cfg_idx_t    cfg_index = CFG_START;
	logic [7:0]  cfg_data = '0;

	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_ready;

	escaped_frame_builder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	logic [7:0] code_start = START_RESET;
	logic [7:0] code_stop  = STOP_RESET;
	logic [7:0] code_esc   = ESC_RESET;
	logic       fr_open = 1'b0;
	logic [7:0] fr_left = '0;
	logic [7:0] fr_sum  = '0;

	wire_byte_t  run_q[$];
	wire_byte_t  want_q[$];
	dir_row_t    dir_tab[$];

	logic        idle_on = 1'b1;
	logic        hold_req = 1'b0;
	int unsigned n_err = 0;
	int unsigned n_words = 0;
	int unsigned n_bytes = 0;
	int unsigned n_frames = 0;
	int unsigned n_settings = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic put_raw(input logic [7:0] b, input logic s);
		wire_byte_t w;
		w.data = b;
		w.is_stop = s;
		w.is_last = 1'b0;
		run_q.push_back(w);
	endtask

	task automatic put_content(input logic [7:0] b);
		if (b == code_esc || b == RESERVED_A || b == RESERVED_B) put_raw(code_esc, 1'b0);
		put_raw(b, 1'b0);
	endtask

	task automatic put_summed(input logic [7:0] b);
		fr_sum = fr_sum + b;
		put_content(b);
	endtask

	task automatic close_frame();
		put_content(fr_sum);
		put_raw(code_stop, 1'b1);
		fr_open = 1'b0;
		fr_left = '0;
		fr_sum = '0;
	endtask

	task automatic frame_predict(input kind_t k, input logic [15:0] a, input logic [7:0] op,
			input logic [7:0] cnt, input logic [7:0] dat);
		wire_byte_t w;
		logic [7:0] len;
		run_q.delete();
		len = cnt + LEN_EXTRA;
		if (k == KIND_BEGIN) begin
			fr_sum = '0;
			put_raw(code_start, 1'b0);
			put_summed(a[7:0]);
			put_summed(a[15:8]);
			put_summed(len);
			put_summed(op);
			fr_open = 1'b1;
			fr_left = cnt;
			if (fr_left == 8'd0) close_frame();
		end else if (fr_open) begin
			put_summed(dat);
			fr_left = fr_left - 8'd1;
			if (fr_left == 8'd0) close_frame();
		end
		if (run_q.size() != 0) begin
			w = run_q.pop_back();
			w.is_last = 1'b1;
			run_q.push_back(w);
		end
	endtask

	task automatic send_word(input kind_t k, input logic [15:0] a, input logic [7:0] op,
			input logic [7:0] cnt, input logic [7:0] dat, input logic typed,
			input logic [3:0] n, input logic [95:0] bytes);
		wire_byte_t w;
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dat, cnt, op, a};
		s_tuser <= k;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		n_words++;
		frame_predict(k, a, op, cnt, dat);
		if (typed) begin
			for (int i = 0; i < n; i++) begin
				w.data = bytes[8*(n-1-i) +: 8];
				w.is_last = (i == n - 1);
				w.is_stop = (i == n - 1);
				want_q.push_back(w);
			end
		end else begin
			foreach (run_q[i]) want_q.push_back(run_q[i]);
		end
	endtask

	task automatic send_begin(input logic [15:0] a, input logic [7:0] op, input logic [7:0] cnt);
		send_word(KIND_BEGIN, a, op, cnt, 8'($urandom_range(0, 255)), 1'b0, '0, '0);
	endtask

	task automatic send_payload(input logic [7:0] dat);
		send_word(KIND_PAYLOAD, 16'($urandom), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), dat, 1'b0, '0, '0);
	endtask

	task automatic add_row(input kind_t k, input logic [15:0] a, input logic [7:0] op,
			input logic [7:0] cnt, input logic [7:0] dat, input logic typed,
			input logic [3:0] n, input logic [95:0] bytes);
		dir_row_t r;
		r.kind = k;
		r.addr = a;
		r.op = op;
		r.cnt = cnt;
		r.dat = dat;
		r.typed = typed;
		r.n = n;
		r.bytes = bytes;
		dir_tab.push_back(r);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [7:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_START:  code_start = v;
			CFG_STOP:   code_stop = v;
			CFG_ESCAPE: code_esc = v;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_codes(input logic [7:0] st, input logic [7:0] sp, input logic [7:0] es);
		cfg_write(CFG_START, st);
		cfg_write(CFG_STOP, sp);
		cfg_write(CFG_ESCAPE, es);
		n_settings++;
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 15))
			0: return code_esc;
			1: return code_start;
			2: return code_stop;
			3: return RESERVED_A;
			4: return RESERVED_B;
			5: return 8'h00;
			6: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic run_random(input int unsigned goal);
		int unsigned sent;
		int unsigned r;
		int unsigned cnt;
		int unsigned cut;
		sent = 0;
		while (sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_payload(pick_byte());
				if (fr_open) sent++;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) cnt = $urandom_range(0, 4);
				else if (r < 95) cnt = $urandom_range(5, 16);
				else cnt = $urandom_range(253, 255);
				if (cnt >= 253) cut = $urandom_range(0, 6);
				else if ($urandom_range(0, 99) < 10) cut = $urandom_range(0, cnt);
				else cut = cnt;
				send_begin({pick_byte(), pick_byte()}, pick_byte(), 8'(cnt));
				for (int i = 0; i < cut; i++) send_payload(pick_byte());
				sent += 1 + cut;
			end
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : check_bytes
		wire_byte_t w;
		if (arst_n && m_axis_tvalid && m_tready) begin
			n_bytes++;
			if (m_axis_tuser) n_frames++;
			if (want_q.size() == 0) begin
				$error("out_byte with no word pending: actual %h", m_axis_tdata);
				n_err++;
			end else begin
				w = want_q.pop_front();
				if (m_axis_tdata !== w.data) begin
					$error("out_byte expected %h actual %h", w.data, m_axis_tdata);
					n_err++;
				end
				if (m_axis_tuser !== w.is_stop) begin
					$error("frame_end expected %b actual %b", w.is_stop, m_axis_tuser);
					n_err++;
				end
				if (m_axis_tlast !== w.is_last) begin
					$error("run_last expected %b actual %b", w.is_last, m_axis_tlast);
					n_err++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'hFF, 1'b1, 4'd0, '0);
		add_row(KIND_BEGIN,   16'h0000, 8'h00, 8'd0,   8'h00, 1'b1, 4'd9,
			96'h02_00_00_10_03_00_10_03_03);
		add_row(KIND_BEGIN,   16'hFFFF, 8'hFF, 8'd0,   8'hFF, 1'b1, 4'd8,
			96'h02_FF_FF_10_03_FF_00_03);
		add_row(KIND_BEGIN,   16'h0202, 8'h02, 8'd0,   8'h00, 1'b1, 4'd11,
			96'h02_10_02_10_02_10_03_10_02_09_03);
		add_row(KIND_BEGIN,   16'h1003, 8'h10, 8'd3,   8'h00, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'h10, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'h02, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'h03, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'hFFFF, 8'hFF, 8'hFF,  8'h55, 1'b1, 4'd0, '0);
		add_row(KIND_BEGIN,   16'h00FF, 8'h80, 8'd252, 8'h00, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'h00, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'hFF, 1'b0, '0, '0);
		add_row(KIND_BEGIN,   16'hABCD, 8'h03, 8'd255, 8'h00, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'h7F, 1'b0, '0, '0);
		add_row(KIND_BEGIN,   16'h5AA5, 8'h01, 8'd1,   8'h00, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'hFF, 1'b0, '0, '0);
		add_row(KIND_BEGIN,   16'h1234, 8'hFE, 8'd253, 8'h00, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'h03, 1'b0, '0, '0);
		add_row(KIND_BEGIN,   16'hFFFF, 8'h00, 8'd254, 8'hFF, 1'b0, '0, '0);
		add_row(KIND_BEGIN,   16'h8001, 8'h10, 8'd2,   8'h00, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'hAA, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'h55, 1'b0, '0, '0);
		add_row(KIND_PAYLOAD, 16'h0000, 8'h00, 8'd0,   8'h01, 1'b0, '0, '0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		n_settings = 1;

		foreach (dir_tab[i])
			send_word(dir_tab[i].kind, dir_tab[i].addr, dir_tab[i].op, dir_tab[i].cnt,
				dir_tab[i].dat, dir_tab[i].typed, dir_tab[i].n, dir_tab[i].bytes);
		drain_and_settle();

		set_codes(8'h00, 8'hFF, 8'hFF);
		hold_req = 1'b1;
		run_random(70);
		drain_and_settle();

		set_codes(8'hFF, 8'h00, 8'h00);
		run_random(70);
		drain_and_settle();

		idle_on = 1'b0;
		set_codes(8'h03, 8'h02, 8'h02);
		run_random(70);
		drain_and_settle();
		idle_on = 1'b1;

		set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		run_random(70);
		drain_and_settle();

		set_codes(START_RESET, STOP_RESET, ESC_RESET);
		run_random(55);
		drain_and_settle();

		$display("Covered %0d input words, %0d output bytes, %0d closed frames", n_words,
			n_bytes, n_frames);
		$display("Used %0d code settings, including extremes and receiver hold-off", n_settings);
		if (n_err == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
